// ===== sv/cfhp_pkg.sv =====
// Shared types and constants for the control frame header parser.
package cfhp_pkg;

  localparam int HDR_BYTES = 44;
  localparam int HP_W      = 6;
  localparam int Q_DEPTH   = 4;
  localparam int Q_AW      = 2;

  typedef enum logic [1:0] {
    KIND_HDR  = 2'd0,
    KIND_PAY  = 2'd1,
    KIND_STAT = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_SHORT   = 3'd1,
    ST_MAGIC   = 3'd2,
    ST_VERSION = 3'd3,
    ST_TYPE    = 3'd4,
    ST_FLAGS   = 3'd5,
    ST_LENGTH  = 3'd6
  } status_t;

  localparam logic [2:0] CFG_MAGIC     = 3'd0;
  localparam logic [2:0] CFG_VERSION   = 3'd1;
  localparam logic [2:0] CFG_FLAGS     = 3'd2;
  localparam logic [2:0] CFG_TYPE_LOW  = 3'd3;
  localparam logic [2:0] CFG_TYPE_HIGH = 3'd4;

  typedef struct packed {
    logic [7:0]  version;
    logic [7:0]  frame_type;
    logic [15:0] flags;
    logic [63:0] session_id;
    logic [63:0] epoch_word;
    logic [63:0] seq_word;
    logic [63:0] ack_word;
    logic [31:0] length;
  } hdr_t;

  // One queue entry: an optional header/payload result, then an optional status.
  typedef struct packed {
    logic    has_data;
    logic    data_is_hdr;
    logic    has_status;
    status_t status;
    logic [7:0] pay_byte;
    hdr_t    hdr;
  } q_entry_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  hdr_version;
    logic [7:0]  frame_type;
    logic [15:0] hdr_flags;
    logic [63:0] session_id;
    logic [63:0] epoch_word;
    logic [63:0] seq_word;
    logic [63:0] ack_word;
    logic [31:0] payload_length;
    logic [7:0]  payload_byte;
    status_t     status;
    logic        last;
  } res_t;

endpackage

// ===== sv/cfhp_if.sv =====
// Valid/ready channel interfaces for input bytes and parser results.
interface cfhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       frame_end;

  modport source(output valid, in_byte, frame_end, input ready);
  modport sink(input valid, in_byte, frame_end, output ready);
endinterface

interface cfhp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  hdr_version;
  logic [7:0]  frame_type;
  logic [15:0] hdr_flags;
  logic [63:0] session_id;
  logic [63:0] epoch_word;
  logic [63:0] seq_word;
  logic [63:0] ack_word;
  logic [31:0] payload_length;
  logic [7:0]  payload_byte;
  logic [2:0]  status;
  logic        last;

  modport source(output valid, kind, hdr_version, frame_type, hdr_flags, session_id,
                 epoch_word, seq_word, ack_word, payload_length, payload_byte, status,
                 last, input ready);
  modport sink(input valid, kind, hdr_version, frame_type, hdr_flags, session_id,
               epoch_word, seq_word, ack_word, payload_length, payload_byte, status,
               last, output ready);
endinterface

// ===== sv/control_frame_header_parser.sv =====
// Control frame header parser top level.
// in_if takes one frame byte per beat, frame_end set on the frame's last byte.
// The first 44 bytes form a little-endian header; once it is complete and
// passes the magic, version, type range and flag mask checks, a header beat
// (kind 0) goes out, followed by payload beats (kind 1) up to the declared
// length. The last byte of a frame also yields a status beat (kind 2, last=1).
// cfg_we/cfg_idx/cfg_wdata write the five check registers; write only when idle.
// Throughput: one input beat per cycle while the queue is not full. A result
// beat passes through the queue and then the output register. A byte that
// produces two results (header or payload plus status) loads the output
// register twice; a 4-entry queue between the front and back ends absorbs this.
// When out_if.ready is low the output beat holds, the queue fills and in_if.ready
// drops once the queue is full.
// Reset (synchronous, rst_n low) empties the queue and output register, clears
// frame state and loads the default check registers.
module control_frame_header_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [31:0] cfg_wdata,
  cfhp_in_if.sink     in_if,
  cfhp_out_if.source  out_if
);

  cfhp_pkg::q_entry_t wr_entry, head;
  cfhp_pkg::q_ctrl_t  q_ctrl;
  logic q_full, q_not_empty, q_push, q_pop;

  assign q_ctrl.push = q_push;
  assign q_ctrl.pop  = q_pop;

  cfhp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_if     (in_if),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (wr_entry)
  );

  cfhp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (q_ctrl),
    .wr_entry  (wr_entry),
    .head      (head),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  cfhp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .not_empty (q_not_empty),
    .pop       (q_pop),
    .out_if    (out_if)
  );

endmodule

// ===== sv/cfhp_front.sv =====
// Front end: config registers, header assembly, header checks, per-beat classification.
module cfhp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_idx,
  input  logic [31:0]         cfg_wdata,
  cfhp_in_if.sink             in_if,
  input  logic                q_full,
  output logic                q_push,
  output cfhp_pkg::q_entry_t  q_entry
);

  logic [31:0] magic_word_r;
  logic [7:0]  exp_version_r;
  logic [15:0] flags_mask_r;
  logic [7:0]  type_low_r;
  logic [7:0]  type_high_r;

  logic [cfhp_pkg::HP_W-1:0] hp_r, hp_nxt;
  logic [31:0]  magic_r, magic_nxt;
  logic [7:0]   version_r, version_nxt;
  logic [7:0]   type_r, type_nxt;
  logic [15:0]  flags_r, flags_nxt;
  logic [255:0] words_r, words_nxt;
  logic [31:0]  length_r, length_nxt;
  logic [32:0]  seen_r, seen_nxt;
  cfhp_pkg::status_t err_r, err_nxt, chk, st;

  logic       acc, hdr_phase, done, pay_emit;
  logic [4:0] widx;
  logic [7:0] b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_word_r  <= '0;
      exp_version_r <= 8'd1;
      flags_mask_r  <= '0;
      type_low_r    <= 8'd1;
      type_high_r   <= 8'd255;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        cfhp_pkg::CFG_MAGIC:     magic_word_r  <= cfg_wdata;
        cfhp_pkg::CFG_VERSION:   exp_version_r <= cfg_wdata[7:0];
        cfhp_pkg::CFG_FLAGS:     flags_mask_r  <= cfg_wdata[15:0];
        cfhp_pkg::CFG_TYPE_LOW:  type_low_r    <= cfg_wdata[7:0];
        cfhp_pkg::CFG_TYPE_HIGH: type_high_r   <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign in_if.ready = !q_full;
  assign acc         = in_if.valid && in_if.ready;
  assign b           = in_if.in_byte;
  assign hdr_phase   = hp_r < cfhp_pkg::HP_W'(cfhp_pkg::HDR_BYTES);
  assign done        = hdr_phase && (hp_r == cfhp_pkg::HP_W'(cfhp_pkg::HDR_BYTES - 1));
  assign widx        = 5'(hp_r - 6'd8);

  // Magic..flags are final before the last header byte, so check from the registers.
  always_comb begin
    if (magic_r != magic_word_r) begin
      chk = cfhp_pkg::ST_MAGIC;
    end else if (version_r != exp_version_r) begin
      chk = cfhp_pkg::ST_VERSION;
    end else if (type_r < type_low_r || type_r > type_high_r) begin
      chk = cfhp_pkg::ST_TYPE;
    end else if ((flags_r & ~flags_mask_r) != 16'd0) begin
      chk = cfhp_pkg::ST_FLAGS;
    end else begin
      chk = cfhp_pkg::ST_OK;
    end
  end

  always_comb begin
    hp_nxt      = hp_r;
    magic_nxt   = magic_r;
    version_nxt = version_r;
    type_nxt    = type_r;
    flags_nxt   = flags_r;
    words_nxt   = words_r;
    length_nxt  = length_r;
    seen_nxt    = seen_r;
    pay_emit    = 1'b0;
    if (hdr_phase) begin
      hp_nxt = hp_r + 6'd1;
      if (hp_r < 6'd4) begin
        magic_nxt[{hp_r[1:0], 3'b000} +: 8] = b;
      end else if (hp_r == 6'd4) begin
        version_nxt = b;
      end else if (hp_r == 6'd5) begin
        type_nxt = b;
      end else if (hp_r < 6'd8) begin
        flags_nxt[{hp_r[0], 3'b000} +: 8] = b;
      end else if (hp_r < 6'd40) begin
        words_nxt[{widx, 3'b000} +: 8] = b;
      end else begin
        length_nxt[{hp_r[1:0], 3'b000} +: 8] = b;
      end
    end else begin
      pay_emit = (err_r == cfhp_pkg::ST_OK) && (seen_r < {1'b0, length_r});
      if (!seen_r[32]) begin
        seen_nxt = seen_r + 33'd1;
      end
    end
    err_nxt = done ? chk : err_r;
  end

  always_comb begin
    if (hp_nxt != cfhp_pkg::HP_W'(cfhp_pkg::HDR_BYTES)) begin
      st = cfhp_pkg::ST_SHORT;
    end else if (err_nxt != cfhp_pkg::ST_OK) begin
      st = err_nxt;
    end else if (seen_nxt != {1'b0, length_nxt}) begin
      st = cfhp_pkg::ST_LENGTH;
    end else begin
      st = cfhp_pkg::ST_OK;
    end
  end

  always_comb begin
    q_entry.has_data        = (done && chk == cfhp_pkg::ST_OK) || pay_emit;
    q_entry.data_is_hdr     = done;
    q_entry.has_status      = in_if.frame_end;
    q_entry.status          = st;
    q_entry.pay_byte        = b;
    q_entry.hdr.version     = version_nxt;
    q_entry.hdr.frame_type  = type_nxt;
    q_entry.hdr.flags       = flags_nxt;
    q_entry.hdr.session_id  = words_nxt[63:0];
    q_entry.hdr.epoch_word  = words_nxt[127:64];
    q_entry.hdr.seq_word    = words_nxt[191:128];
    q_entry.hdr.ack_word    = words_nxt[255:192];
    q_entry.hdr.length      = length_nxt;
  end

  assign q_push = acc && (q_entry.has_data || q_entry.has_status);

  always_ff @(posedge clk) begin
    if (!rst_n || (acc && in_if.frame_end)) begin
      hp_r      <= '0;
      magic_r   <= '0;
      version_r <= '0;
      type_r    <= '0;
      flags_r   <= '0;
      words_r   <= '0;
      length_r  <= '0;
      seen_r    <= '0;
      err_r     <= cfhp_pkg::ST_OK;
    end else if (acc) begin
      hp_r      <= hp_nxt;
      magic_r   <= magic_nxt;
      version_r <= version_nxt;
      type_r    <= type_nxt;
      flags_r   <= flags_nxt;
      words_r   <= words_nxt;
      length_r  <= length_nxt;
      seen_r    <= seen_nxt;
      err_r     <= err_nxt;
    end
  end

endmodule

// ===== sv/cfhp_queue.sv =====
// Small FIFO of classified beats between front and back.
module cfhp_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  cfhp_pkg::q_ctrl_t  ctrl,
  input  cfhp_pkg::q_entry_t wr_entry,
  output cfhp_pkg::q_entry_t head,
  output logic               not_empty,
  output logic               full
);

  cfhp_pkg::q_entry_t mem_r [cfhp_pkg::Q_DEPTH];
  logic [cfhp_pkg::Q_AW-1:0] wp_r, rp_r;
  logic [cfhp_pkg::Q_AW:0]   cnt_r;
  logic do_push, do_pop;

  assign full      = cnt_r == (cfhp_pkg::Q_AW+1)'(cfhp_pkg::Q_DEPTH);
  assign not_empty = cnt_r != '0;
  assign do_push   = ctrl.push && !full;
  assign do_pop    = ctrl.pop && not_empty;
  assign head      = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= rp_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ===== sv/cfhp_back.sv =====
// Back end: expands queue entries into result beats through an output register.
module cfhp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  cfhp_pkg::q_entry_t head,
  input  logic               not_empty,
  output logic               pop,
  cfhp_out_if.source         out_if
);

  cfhp_pkg::res_t res_r, res_nxt;
  logic ov_r;
  logic second_r, second_nxt;
  logic load;

  assign load = not_empty && (!ov_r || out_if.ready);

  always_comb begin
    res_nxt    = '0;
    pop        = 1'b0;
    second_nxt = second_r;
    if (head.has_data && !second_r) begin
      if (head.data_is_hdr) begin
        res_nxt.kind           = cfhp_pkg::KIND_HDR;
        res_nxt.hdr_version    = head.hdr.version;
        res_nxt.frame_type     = head.hdr.frame_type;
        res_nxt.hdr_flags      = head.hdr.flags;
        res_nxt.session_id     = head.hdr.session_id;
        res_nxt.epoch_word     = head.hdr.epoch_word;
        res_nxt.seq_word       = head.hdr.seq_word;
        res_nxt.ack_word       = head.hdr.ack_word;
        res_nxt.payload_length = head.hdr.length;
      end else begin
        res_nxt.kind         = cfhp_pkg::KIND_PAY;
        res_nxt.payload_byte = head.pay_byte;
      end
      res_nxt.status = cfhp_pkg::ST_OK;
      if (head.has_status) begin
        second_nxt = 1'b1;
      end else begin
        pop = load;
      end
    end else begin
      res_nxt.kind   = cfhp_pkg::KIND_STAT;
      res_nxt.status = head.status;
      res_nxt.last   = 1'b1;
      second_nxt     = 1'b0;
      pop            = load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r     <= 1'b0;
      second_r <= 1'b0;
    end else begin
      if (load) begin
        ov_r     <= 1'b1;
        second_r <= second_nxt;
      end else if (out_if.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  assign out_if.valid          = ov_r;
  assign out_if.kind           = res_r.kind;
  assign out_if.hdr_version    = res_r.hdr_version;
  assign out_if.frame_type     = res_r.frame_type;
  assign out_if.hdr_flags      = res_r.hdr_flags;
  assign out_if.session_id     = res_r.session_id;
  assign out_if.epoch_word     = res_r.epoch_word;
  assign out_if.seq_word       = res_r.seq_word;
  assign out_if.ack_word       = res_r.ack_word;
  assign out_if.payload_length = res_r.payload_length;
  assign out_if.payload_byte   = res_r.payload_byte;
  assign out_if.status         = res_r.status;
  assign out_if.last           = res_r.last;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the control frame header parser: framed byte traffic, beat checks.
module tb;
  import cfhp_pkg::*;

  localparam int unsigned IDLE_LIMIT  = 4000;
  localparam int unsigned RAND_BYTES  = 1300;
  localparam int unsigned HOLD_CYCLES = 300;

  class frame_checker;
    logic [31:0] magic_cfg;
    logic [7:0]  version_cfg;
    logic [15:0] mask_cfg;
    logic [7:0]  type_lo_cfg;
    logic [7:0]  type_hi_cfg;
    int unsigned hdr_pos;
    logic [31:0] magic_acc;
    hdr_t        hdr;
    logic [32:0] pay_seen;
    status_t     hdr_status;
    res_t        pending[$];
    int unsigned errors;

    function new();
      magic_cfg   = '0;
      version_cfg = 8'd1;
      mask_cfg    = '0;
      type_lo_cfg = 8'd1;
      type_hi_cfg = 8'hff;
      errors      = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      hdr_pos    = 0;
      magic_acc  = '0;
      hdr        = '0;
      pay_seen   = '0;
      hdr_status = ST_OK;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        CFG_MAGIC:     magic_cfg   = val;
        CFG_VERSION:   version_cfg = val[7:0];
        CFG_FLAGS:     mask_cfg    = val[15:0];
        CFG_TYPE_LOW:  type_lo_cfg = val[7:0];
        CFG_TYPE_HIGH: type_hi_cfg = val[7:0];
        default: ;
      endcase
    endfunction

    // checks run in priority order; first failure wins
    function status_t header_verdict();
      if (magic_acc != magic_cfg) return ST_MAGIC;
      if (hdr.version != version_cfg) return ST_VERSION;
      if (hdr.frame_type < type_lo_cfg || hdr.frame_type > type_hi_cfg) return ST_TYPE;
      if ((hdr.flags & ~mask_cfg) != 16'h0) return ST_FLAGS;
      return ST_OK;
    endfunction

    function void take_byte(logic [7:0] b, logic fin);
      res_t    r;
      status_t st;
      if (hdr_pos < HDR_BYTES) begin
        if (hdr_pos < 4) magic_acc[8*hdr_pos +: 8] = b;
        else if (hdr_pos == 4) hdr.version = b;
        else if (hdr_pos == 5) hdr.frame_type = b;
        else if (hdr_pos < 8) hdr.flags[8*(hdr_pos-6) +: 8] = b;
        else if (hdr_pos < 16) hdr.session_id[8*(hdr_pos-8) +: 8] = b;
        else if (hdr_pos < 24) hdr.epoch_word[8*(hdr_pos-16) +: 8] = b;
        else if (hdr_pos < 32) hdr.seq_word[8*(hdr_pos-24) +: 8] = b;
        else if (hdr_pos < 40) hdr.ack_word[8*(hdr_pos-32) +: 8] = b;
        else hdr.length[8*(hdr_pos-40) +: 8] = b;
        hdr_pos++;
        if (hdr_pos == HDR_BYTES) begin
          hdr_status = header_verdict();
          if (hdr_status == ST_OK) begin
            r = '0;
            r.kind           = KIND_HDR;
            r.hdr_version    = hdr.version;
            r.frame_type     = hdr.frame_type;
            r.hdr_flags      = hdr.flags;
            r.session_id     = hdr.session_id;
            r.epoch_word     = hdr.epoch_word;
            r.seq_word       = hdr.seq_word;
            r.ack_word       = hdr.ack_word;
            r.payload_length = hdr.length;
            pending.insert(pending.size(), r);
          end
        end
      end else begin
        if (hdr_status == ST_OK && pay_seen < {1'b0, hdr.length}) begin
          r = '0;
          r.kind         = KIND_PAY;
          r.payload_byte = b;
          pending.insert(pending.size(), r);
        end
        if (!pay_seen[32]) pay_seen++;
      end
      if (fin) begin
        if (hdr_pos < HDR_BYTES) st = ST_SHORT;
        else if (hdr_status != ST_OK) st = hdr_status;
        else if (pay_seen != {1'b0, hdr.length}) st = ST_LENGTH;
        else st = ST_OK;
        r = '0;
        r.kind   = KIND_STAT;
        r.status = st;
        r.last   = 1'b1;
        pending.insert(pending.size(), r);
        clear_frame();
      end
    endfunction

    function bit field_ok(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function void check_beat(res_t got);
      res_t want;
      bit   ok;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result beat, kind %0h", $time, got.kind);
        errors++;
        return;
      end
      want = pending.pop_front();
      ok = 1'b1;
      ok &= field_ok("kind", want.kind, got.kind);
      ok &= field_ok("hdr_version", want.hdr_version, got.hdr_version);
      ok &= field_ok("frame_type", want.frame_type, got.frame_type);
      ok &= field_ok("hdr_flags", want.hdr_flags, got.hdr_flags);
      ok &= field_ok("session_id", want.session_id, got.session_id);
      ok &= field_ok("epoch_word", want.epoch_word, got.epoch_word);
      ok &= field_ok("seq_word", want.seq_word, got.seq_word);
      ok &= field_ok("ack_word", want.ack_word, got.ack_word);
      ok &= field_ok("payload_length", want.payload_length, got.payload_length);
      ok &= field_ok("payload_byte", want.payload_byte, got.payload_byte);
      ok &= field_ok("status", want.status, got.status);
      ok &= field_ok("last", want.last, got.last);
      if (!ok) errors++;
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [31:0] cfg_wdata;

  cfhp_in_if  in_if();
  cfhp_out_if out_if();

  control_frame_header_parser dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_if     (in_if),
    .out_if    (out_if)
  );

  frame_checker chk;
  int unsigned  sent_bytes;
  int unsigned  idle_cycles;
  bit           tx_steady;
  bit           rx_steady;
  bit           hold_req;
  res_t         beat;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) chk.take_byte(in_if.in_byte, in_if.frame_end);
      if (out_if.valid && out_if.ready) begin
        beat.kind           = kind_t'(out_if.kind);
        beat.hdr_version    = out_if.hdr_version;
        beat.frame_type     = out_if.frame_type;
        beat.hdr_flags      = out_if.hdr_flags;
        beat.session_id     = out_if.session_id;
        beat.epoch_word     = out_if.epoch_word;
        beat.seq_word       = out_if.seq_word;
        beat.ack_word       = out_if.ack_word;
        beat.payload_length = out_if.payload_length;
        beat.payload_byte   = out_if.payload_byte;
        beat.status         = status_t'(out_if.status);
        beat.last           = out_if.last;
        chk.check_beat(beat);
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side: random back-pressure, plus one long hold-off on request
  initial begin
    int unsigned gap;
    out_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        gap = rx_steady ? 0 : pick_gap();
        if (gap != 0) begin
          out_if.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_if.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int unsigned gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.in_byte   <= b;
    in_if.frame_end <= fin;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sent_bytes++;
  endtask

  task automatic send_frame(input logic [31:0] mg, input hdr_t h, input int unsigned npay,
                            input int unsigned cut);
    logic [7:0]   fb[$];
    logic [255:0] words;
    int unsigned  n;
    words = {h.ack_word, h.seq_word, h.epoch_word, h.session_id};
    for (int i = 0; i < 4; i++) fb.insert(fb.size(), mg[8*i +: 8]);
    fb.insert(fb.size(), h.version);
    fb.insert(fb.size(), h.frame_type);
    for (int i = 0; i < 2; i++) fb.insert(fb.size(), h.flags[8*i +: 8]);
    for (int i = 0; i < 32; i++) fb.insert(fb.size(), words[8*i +: 8]);
    for (int i = 0; i < 4; i++) fb.insert(fb.size(), h.length[8*i +: 8]);
    for (int i = 0; i < npay; i++) fb.insert(fb.size(), 8'($urandom));
    n = (cut != 0 && cut < fb.size()) ? cut : fb.size();
    for (int i = 0; i < n; i++) send_byte(fb[i], i == n - 1);
  endtask

  function automatic hdr_t good_hdr(logic [31:0] len);
    hdr_t h;
    h.version = chk.version_cfg;
    if (chk.type_lo_cfg <= chk.type_hi_cfg)
      h.frame_type = 8'($urandom_range(chk.type_hi_cfg, chk.type_lo_cfg));
    else
      h.frame_type = 8'($urandom);
    h.flags      = 16'($urandom) & chk.mask_cfg;
    h.session_id = {$urandom, $urandom};
    h.epoch_word = {$urandom, $urandom};
    h.seq_word   = {$urandom, $urandom};
    h.ack_word   = {$urandom, $urandom};
    h.length     = len;
    return h;
  endfunction

  function automatic logic [7:0] bad_type();
    if (chk.type_lo_cfg > chk.type_hi_cfg) return 8'($urandom);
    if (chk.type_lo_cfg != 8'h00 && (chk.type_hi_cfg == 8'hff || $urandom_range(0, 1)))
      return 8'($urandom_range(chk.type_lo_cfg - 8'd1, 0));
    if (chk.type_hi_cfg != 8'hff) return 8'($urandom_range(255, chk.type_hi_cfg + 8'd1));
    return 8'($urandom);
  endfunction

  task automatic rand_frame();
    int unsigned r;
    int unsigned npay;
    logic [31:0] len;
    logic [31:0] mg;
    hdr_t        h;
    r   = $urandom_range(0, 99);
    len = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 12);
    h   = good_hdr(len);
    mg  = chk.magic_cfg;
    npay = (len > 12) ? $urandom_range(0, 4) : len;
    if (r >= 55) npay = $urandom_range(0, 6);
    if (r < 42) begin
      send_frame(mg, h, npay, 0);
    end else if (r < 55) begin
      // payload count off from the declared length
      if (len <= 12) begin
        if (len > 0 && $urandom_range(0, 1)) npay = $urandom_range(0, len - 1);
        else npay = len + $urandom_range(1, 3);
      end
      send_frame(mg, h, npay, 0);
    end else if (r < 62) begin
      mg = $urandom_range(0, 1) ? chk.magic_cfg ^ (32'h1 << $urandom_range(0, 31)) : $urandom;
      if ($urandom_range(0, 1)) h.version = 8'($urandom);
      send_frame(mg, h, npay, 0);
    end else if (r < 69) begin
      h.version = chk.version_cfg ^ 8'($urandom_range(1, 255));
      if ($urandom_range(0, 1)) h.frame_type = 8'($urandom);
      send_frame(mg, h, npay, 0);
    end else if (r < 76) begin
      h.frame_type = bad_type();
      if ($urandom_range(0, 1)) h.flags = 16'($urandom);
      send_frame(mg, h, npay, 0);
    end else if (r < 83) begin
      if (chk.mask_cfg != 16'hffff) begin
        h.flags = 16'h0;
        while ((h.flags & ~chk.mask_cfg) == 16'h0) h.flags = 16'($urandom);
      end
      send_frame(mg, h, npay, 0);
    end else if (r < 92) begin
      send_frame(mg, h, 0, $urandom_range(1, 43));
    end else begin
      npay = $urandom_range(1, 60);
      for (int i = 0; i < npay; i++) send_byte(8'($urandom), i == npay - 1);
    end
  endtask

  task automatic run_random(input int unsigned budget);
    int unsigned stop_at;
    stop_at = sent_bytes + budget;
    while (sent_bytes < stop_at) rand_frame();
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (chk.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    chk.set_reg(idx, val);
  endtask

  initial begin
    hdr_t        h;
    logic [31:0] v;
    chk             = new();
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = CFG_MAGIC;
    cfg_wdata       = '0;
    in_if.valid     = 1'b0;
    in_if.in_byte   = '0;
    in_if.frame_end = 1'b0;
    sent_bytes      = 0;
    idle_cycles     = 0;
    tx_steady       = 1'b0;
    rx_steady       = 1'b0;
    hold_req        = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed frames under reset settings
    send_frame(chk.magic_cfg, good_hdr(0), 0, 0);
    h = good_hdr(3);
    h.frame_type = 8'hff;
    send_frame(chk.magic_cfg, h, 3, 0);
    h = good_hdr(3);
    h.frame_type = 8'h01;
    send_frame(chk.magic_cfg, h, 5, 0);
    send_frame(chk.magic_cfg, good_hdr(4), 1, 0);
    send_frame(chk.magic_cfg, good_hdr(32'hffff_ffff), 2, 0);
    send_frame(chk.magic_cfg, good_hdr(0), 0, 1);
    send_frame(chk.magic_cfg, good_hdr(5), 0, 43);
    send_frame(32'hffff_ffff, good_hdr(0), 0, 0);
    h = good_hdr(2);
    h.version = 8'h00;
    send_frame(32'h8000_0000, h, 2, 0);
    h = good_hdr(2);
    h.version = 8'hff;
    send_frame(chk.magic_cfg, h, 2, 0);
    h = good_hdr(1);
    h.frame_type = 8'h00;
    send_frame(chk.magic_cfg, h, 1, 0);
    h = good_hdr(0);
    h.flags = 16'h8001;
    send_frame(chk.magic_cfg, h, 3, 0);
    drain();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin
          write_reg(CFG_MAGIC, $urandom);
          write_reg(CFG_VERSION, $urandom);
          write_reg(CFG_FLAGS, $urandom);
          write_reg(CFG_TYPE_LOW, $urandom_range(0, 127));
          write_reg(CFG_TYPE_HIGH, $urandom_range(128, 255));
          hold_req = 1'b1;
        end
        1: begin
          write_reg(CFG_MAGIC, 32'hffff_ffff);
          write_reg(CFG_VERSION, 32'hff);
          write_reg(CFG_FLAGS, 32'hffff);
          write_reg(CFG_TYPE_LOW, 32'h0);
          write_reg(CFG_TYPE_HIGH, 32'hff);
          tx_steady = 1'b1;
          rx_steady = 1'b1;
        end
        2: begin
          // empty type range: nothing is a known type
          write_reg(CFG_MAGIC, 32'h0);
          write_reg(CFG_VERSION, 32'h0);
          write_reg(CFG_FLAGS, 32'h0);
          write_reg(CFG_TYPE_LOW, 32'd200);
          write_reg(CFG_TYPE_HIGH, 32'd100);
          tx_steady = 1'b0;
          rx_steady = 1'b0;
        end
        3: begin
          v = $urandom;
          write_reg(CFG_MAGIC, $urandom);
          write_reg(CFG_FLAGS, $urandom);
          write_reg(CFG_TYPE_LOW, v);
          write_reg(CFG_TYPE_HIGH, v);
          rx_steady = 1'b1;
        end
        default: begin
          write_reg(CFG_MAGIC, $urandom);
          write_reg(CFG_VERSION, $urandom);
          write_reg(CFG_FLAGS, $urandom);
          write_reg(CFG_TYPE_LOW, 32'h0);
          write_reg(CFG_TYPE_HIGH, $urandom_range(0, 254));
          rx_steady = 1'b0;
        end
      endcase
      run_random(RAND_BYTES / 5);
      drain();
    end

    if (chk.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
